@@ rtl/rmq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the rotation matrix to quaternion block
// Item payload structs, field widths and pipeline sizing constants.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int ElemW  = 16;
    localparam int RadW   = 19;              // radicand, signed, 1 + up to 3*32768
    localparam int RootW  = 18;              // floor(sqrt(rad << 16)) < 2^18
    localparam int RootSteps = RootW;        // one result bit per stage
    localparam int NumW   = 17;              // element sum or difference
    localparam int MagW   = 17;              // |num|
    localparam int QuotW  = 16;              // quotient bits that matter before clamp
    localparam int DivDW  = MagW + 14 + 1;   // dividend (mag << 14) + s/2
    localparam logic [ElemW-1:0] OneQ14 = 16'd16384;

    typedef enum logic [1:0] {
        SEL_W = 2'd0,
        SEL_X = 2'd1,
        SEL_Y = 2'd2,
        SEL_Z = 2'd3
    } sel_t;

    typedef struct packed {
        logic signed [ElemW-1:0] r00;
        logic signed [ElemW-1:0] r01;
        logic signed [ElemW-1:0] r02;
        logic signed [ElemW-1:0] r10;
        logic signed [ElemW-1:0] r11;
        logic signed [ElemW-1:0] r12;
        logic signed [ElemW-1:0] r20;
        logic signed [ElemW-1:0] r21;
        logic signed [ElemW-1:0] r22;
    } mat_t;

    typedef struct packed {
        logic signed [ElemW-1:0] quat_w;
        logic signed [ElemW-1:0] quat_x;
        logic signed [ElemW-1:0] quat_y;
        logic signed [ElemW-1:0] quat_z;
        logic                    invalid;
    } quat_t;

    // Per-item context that rides alongside the root and divide stages
    typedef struct packed {
        sel_t                   sel;
        logic                   bad;
        logic signed [NumW-1:0] num0;
        logic signed [NumW-1:0] num1;
        logic signed [NumW-1:0] num2;
    } ctx_t;

endpackage

@@ rtl/rmq_sqrt_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt_pipe: pipelined integer square root
// Restoring root, one result bit per stage, with a side context carried along.
// ----------------------------------------------------------------------------
module rmq_sqrt_pipe #(
    parameter int CTX_W = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [rmq_pkg::RadW-2:0]            in_rad,
    input  logic [CTX_W-1:0]                    in_ctx,
    output logic                                out_valid,
    output logic [rmq_pkg::RootW-1:0]           out_root,
    output logic [CTX_W-1:0]                    out_ctx
);
    import rmq_pkg::*;

    localparam int OpW = 2 * RootW;            // operand rad << 16, 34 bits fit in 36
    localparam int RemW = RootW + 2;

    logic [RootSteps-1:0]         vld_reg;
    logic [OpW-1:0]               op_reg   [RootSteps];
    logic [RemW-1:0]              rem_reg  [RootSteps];
    logic [RootW-1:0]             root_reg [RootSteps];
    logic [CTX_W-1:0]             ctx_reg  [RootSteps];

    logic [OpW-1:0]               op_in     [RootSteps];
    logic [RemW-1:0]              rem_in    [RootSteps];
    logic [RootW-1:0]             root_in   [RootSteps];
    logic [RemW-1:0]              rem_next  [RootSteps];
    logic [RemW-1:0]              trial     [RootSteps];
    logic [RootW-1:0]             root_next [RootSteps];

    always_comb begin
        op_in[0]   = {{(OpW-(RadW-1)-16){1'b0}}, in_rad, 16'd0};
        rem_in[0]  = '0;
        root_in[0] = '0;
        for (int k = 1; k < RootSteps; k++) begin
            op_in[k]   = op_reg[k-1];
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
        end
        for (int k = 0; k < RootSteps; k++) begin
            // bring down two operand bits, try 4*root+1
            rem_next[k] = {rem_in[k][RemW-3:0], op_in[k][OpW-1 -: 2]};
            trial[k]    = {root_in[k], 2'b01};
            if (rem_next[k] >= trial[k]) begin
                rem_next[k]  = rem_next[k] - trial[k];
                root_next[k] = {root_in[k][RootW-2:0], 1'b1};
            end else begin
                root_next[k] = {root_in[k][RootW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[RootSteps-2:0], in_valid};
        end
        if (adv) begin
            ctx_reg[0] <= in_ctx;
            for (int k = 0; k < RootSteps; k++) begin
                op_reg[k]   <= {op_in[k][OpW-3:0], 2'b00};
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
            for (int k = 1; k < RootSteps; k++) begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[RootSteps-1];
    assign out_root  = root_reg[RootSteps-1];
    assign out_ctx   = ctx_reg[RootSteps-1];

endmodule

@@ rtl/rmq_div_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div_pipe: pipelined restoring divider for one quotient lane
// Computes round-half-away(num * 2^14 / s) saturated to 16 bits signed.
// ----------------------------------------------------------------------------
module rmq_div_pipe (
    input  logic                              aclk,
    input  logic                              adv,
    input  logic signed [rmq_pkg::NumW-1:0]   num,
    input  logic [rmq_pkg::RootW-1:0]         s,
    output logic signed [rmq_pkg::ElemW-1:0]  q_out
);
    import rmq_pkg::*;

    // q = ((mag<<14) + s/2) / s. Only QuotW+1 quotient bits are needed:
    // anything at 2^17 or above saturates, tracked by a sticky flag. The
    // upper dividend bits seed the remainder.
    localparam int Steps = QuotW + 1;
    localparam int RemW  = RootW + 1;

    logic [DivDW-1:0]  dvd_reg [Steps];
    logic [RemW-1:0]   rem_reg [Steps];
    logic [Steps-1:0]  q_reg   [Steps];
    logic [RootW-1:0]  s_reg   [Steps];
    logic              neg_reg [Steps];
    logic              ovf_reg [Steps];

    logic [DivDW-1:0]  dvd_in  [Steps];
    logic [RemW-1:0]   rem_in  [Steps];
    logic [Steps-1:0]  q_in    [Steps];
    logic [RootW-1:0]  s_in    [Steps];
    logic              neg_in  [Steps];
    logic              ovf_in  [Steps];
    logic [RemW:0]     rem_sh  [Steps];
    logic [RemW-1:0]   rem_next [Steps];
    logic [Steps-1:0]  qb;

    logic [MagW-1:0]   mag;
    logic [DivDW-1:0]  dvd0;
    logic              hi_ovf;

    always_comb begin
        mag  = num[NumW-1] ? MagW'(-num) : MagW'(num);
        dvd0 = {1'b0, mag, 14'd0} + DivDW'(s >> 1);
        // quotient bits above Steps: dividend top part already >= s
        hi_ovf = (RootW'(dvd0[DivDW-1:Steps]) >= s);
        dvd_in[0] = dvd0;
        rem_in[0] = RemW'(dvd0[DivDW-1:Steps]);
        q_in[0]   = '0;
        s_in[0]   = s;
        neg_in[0] = num[NumW-1];
        ovf_in[0] = hi_ovf;
        for (int k = 1; k < Steps; k++) begin
            dvd_in[k] = dvd_reg[k-1];
            rem_in[k] = rem_reg[k-1];
            q_in[k]   = q_reg[k-1];
            s_in[k]   = s_reg[k-1];
            neg_in[k] = neg_reg[k-1];
            ovf_in[k] = ovf_reg[k-1];
        end
        for (int k = 0; k < Steps; k++) begin
            rem_sh[k]   = {rem_in[k], dvd_in[k][Steps-1-k]};
            qb[k]       = (rem_sh[k] >= {2'b00, s_in[k]});
            rem_next[k] = qb[k] ? RemW'(rem_sh[k] - {2'b00, s_in[k]}) : RemW'(rem_sh[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < Steps; k++) begin
                dvd_reg[k] <= dvd_in[k];
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= {q_in[k][Steps-2:0], qb[k]};
                s_reg[k]   <= s_in[k];
                neg_reg[k] <= neg_in[k];
                ovf_reg[k] <= ovf_in[k];
            end
        end
    end

    logic [Steps-1:0] qf;
    always_comb begin
        qf = q_reg[Steps-1];
        if (neg_reg[Steps-1]) begin
            if (ovf_reg[Steps-1] || qf > Steps'(32768)) q_out = 16'sh8000;
            else q_out = ElemW'(-$signed({1'b0, qf}));
        end else begin
            if (ovf_reg[Steps-1] || qf > Steps'(32767)) q_out = 16'sh7fff;
            else q_out = ElemW'(qf);
        end
    end

endmodule

@@ rtl/rotation_matrix_to_quaternion_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit: 3x3 rotation matrix to unit quaternion
// Shepperd branch selection, pipelined square root and three dividers.
// ----------------------------------------------------------------------------
//  channel | ports              | payload | direction
//  --------+--------------------+---------+----------
//  input   | s_valid/s_ready    | mat_t   | in
//  result  | m_valid/m_ready    | quat_t  | out
//
//  One item per cycle sustained while the output is taken. The pipe has
//  one front stage, eighteen square root stages, seventeen divide stages
//  and the output register. Reset (aresetn low, synchronous) clears all
//  valid bits. The whole pipe advances together; it holds when the output
//  register is full and not taken, so a stall drops and repeats nothing.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rmq_pkg::mat_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output rmq_pkg::quat_t  m_data
);
    import rmq_pkg::*;

    localparam int CtxW = $bits(ctx_t);
    localparam int DivLat = QuotW + 1;

    logic adv;
    logic m_valid_reg;
    quat_t m_data_reg;

    // Advance everything whenever the output slot is free or being drained
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ---------------- front stage: branch, radicand, numerators ----------
    logic signed [RadW-1:0] tr, rad;
    ctx_t ctx_next;
    always_comb begin
        tr = RadW'(s_data.r00) + RadW'(s_data.r11) + RadW'(s_data.r22);
        ctx_next = '0;
        if (tr > 0) begin
            ctx_next.sel  = SEL_W;
            rad = RadW'(OneQ14) + tr;
            ctx_next.num0 = NumW'(s_data.r21) - NumW'(s_data.r12);
            ctx_next.num1 = NumW'(s_data.r02) - NumW'(s_data.r20);
            ctx_next.num2 = NumW'(s_data.r10) - NumW'(s_data.r01);
        end else if (s_data.r00 > s_data.r11 && s_data.r00 > s_data.r22) begin
            ctx_next.sel  = SEL_X;
            rad = RadW'(OneQ14) + RadW'(s_data.r00) - RadW'(s_data.r11)
                - RadW'(s_data.r22);
            ctx_next.num0 = NumW'(s_data.r21) - NumW'(s_data.r12);
            ctx_next.num1 = NumW'(s_data.r01) + NumW'(s_data.r10);
            ctx_next.num2 = NumW'(s_data.r02) + NumW'(s_data.r20);
        end else if (s_data.r11 > s_data.r22) begin
            ctx_next.sel  = SEL_Y;
            rad = RadW'(OneQ14) + RadW'(s_data.r11) - RadW'(s_data.r00)
                - RadW'(s_data.r22);
            ctx_next.num0 = NumW'(s_data.r02) - NumW'(s_data.r20);
            ctx_next.num1 = NumW'(s_data.r01) + NumW'(s_data.r10);
            ctx_next.num2 = NumW'(s_data.r12) + NumW'(s_data.r21);
        end else begin
            ctx_next.sel  = SEL_Z;
            rad = RadW'(OneQ14) + RadW'(s_data.r22) - RadW'(s_data.r00)
                - RadW'(s_data.r11);
            ctx_next.num0 = NumW'(s_data.r10) - NumW'(s_data.r01);
            ctx_next.num1 = NumW'(s_data.r02) + NumW'(s_data.r20);
            ctx_next.num2 = NumW'(s_data.r12) + NumW'(s_data.r21);
        end
        ctx_next.bad = (rad <= 0);
    end

    logic                  f_valid_reg;
    logic [RadW-2:0]       f_rad_reg;
    ctx_t                  f_ctx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg <= s_valid;
        end
        if (adv) begin
            // a bad radicand feeds zero into the root; its result is masked later
            f_rad_reg <= ctx_next.bad ? '0 : rad[RadW-2:0];
            f_ctx_reg <= ctx_next;
        end
    end

    // ---------------- square root ----------------------------------------
    logic              r_valid;
    logic [RootW-1:0]  r_root;
    logic [CtxW-1:0]   r_ctx_bits;
    ctx_t              r_ctx;

    rmq_sqrt_pipe #(.CTX_W(CtxW)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (f_valid_reg),
        .in_rad    (f_rad_reg),
        .in_ctx    (f_ctx_reg),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_ctx   (r_ctx_bits)
    );
    assign r_ctx = ctx_t'(r_ctx_bits);

    // Keep divisor nonzero for masked items
    logic [RootW-1:0] s_div;
    assign s_div = r_ctx.bad ? RootW'(1) : r_root;

    // ---------------- dividers, plus a delay line for the side info ------
    logic signed [ElemW-1:0] q0, q1, q2;

    rmq_div_pipe u_div0 (.aclk(aclk), .adv(adv), .num(r_ctx.num0), .s(s_div), .q_out(q0));
    rmq_div_pipe u_div1 (.aclk(aclk), .adv(adv), .num(r_ctx.num1), .s(s_div), .q_out(q1));
    rmq_div_pipe u_div2 (.aclk(aclk), .adv(adv), .num(r_ctx.num2), .s(s_div), .q_out(q2));

    logic [DivLat-1:0]       d_valid_reg;
    sel_t                    d_sel_reg  [DivLat];
    logic                    d_bad_reg  [DivLat];
    logic [RootW-1:0]        d_root_reg [DivLat];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= '0;
        end else if (adv) begin
            d_valid_reg <= {d_valid_reg[DivLat-2:0], r_valid};
        end
        if (adv) begin
            d_sel_reg[0]  <= r_ctx.sel;
            d_bad_reg[0]  <= r_ctx.bad;
            d_root_reg[0] <= r_root;
            for (int k = 1; k < DivLat; k++) begin
                d_sel_reg[k]  <= d_sel_reg[k-1];
                d_bad_reg[k]  <= d_bad_reg[k-1];
                d_root_reg[k] <= d_root_reg[k-1];
            end
        end
    end

    // ---------------- assemble and register the result -------------------
    logic [RootW-1:0]        c_sum;
    logic signed [ElemW-1:0] comp;
    quat_t                   res_next;
    sel_t                    sel_last;

    always_comb begin
        sel_last = d_sel_reg[DivLat-1];
        c_sum = (d_root_reg[DivLat-1] + RootW'(2)) >> 2;
        comp  = (c_sum > RootW'(32767)) ? 16'sh7fff : ElemW'(c_sum);
        res_next = '0;
        unique case (sel_last)
            SEL_W: begin
                res_next.quat_w = comp; res_next.quat_x = q0;
                res_next.quat_y = q1;   res_next.quat_z = q2;
            end
            SEL_X: begin
                res_next.quat_w = q0;   res_next.quat_x = comp;
                res_next.quat_y = q1;   res_next.quat_z = q2;
            end
            SEL_Y: begin
                res_next.quat_w = q0;   res_next.quat_x = q1;
                res_next.quat_y = comp; res_next.quat_z = q2;
            end
            SEL_Z: begin
                res_next.quat_w = q0;   res_next.quat_x = q1;
                res_next.quat_y = q2;   res_next.quat_z = comp;
            end
            default: res_next = '0;
        endcase
        if (d_bad_reg[DivLat-1]) begin
            res_next = '0;
            res_next.invalid = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= d_valid_reg[DivLat-1];
        end
        if (adv) begin
            m_data_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- checks ---------------------------------------------
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_ready_follows_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready out of step with output slot");
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.invalid |-> m_data.quat_w == 0 && m_data.quat_x == 0
            && m_data.quat_y == 0 && m_data.quat_z == 0)
        else $error("invalid result carries nonzero components");

endmodule
